### hdl/png_chunk_framer_core_assert.svh
// assertion macros shared by the png chunk framer rtl
// expects signals named clock and reset (synchronous, active high) in the using module
`ifndef PNG_CHUNK_FRAMER_CORE_ASSERT_SVH
`define PNG_CHUNK_FRAMER_CORE_ASSERT_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define PCF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked at every rising clock edge outside reset
`define PCF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/pcf_pkg.sv
// types, constants and crc functions for the png chunk framer
// no dependencies; used by every other rtl file but the assertion macro header
`default_nettype none

package pcf_pkg;

   // significant bits of the chunk length field
   localparam int LENGTH_BITS = 31;
   localparam int LEN_FIELD_BITS = 31;
   localparam int TYPE_BITS = 32;
   localparam int BYTE_BITS = 8;

   // longest run of result transactions one request can cause
   localparam int RUN_MAX = 12;
   localparam int RUN_CNT_BITS = $clog2(RUN_MAX + 1);

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   // request kinds
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_DATA  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_CHUNK   = 2'd1,
      STATUS_CHUNK_OPEN = 2'd2
   } status_type;

   typedef struct packed {
      logic                      req_type;
      logic [TYPE_BITS-1:0]      chunk_type;
      logic [LEN_FIELD_BITS-1:0] chunk_length;
      logic [BYTE_BITS-1:0]      data_byte;
   } item_type;

   typedef struct packed {
      logic [RUN_MAX-1:0][BYTE_BITS-1:0] bytes;
      logic [RUN_CNT_BITS-1:0]           count;
      logic                              done;
      status_type                        status;
   } run_type;

   // one byte through the reflected crc-32, lsb first
   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'h000000, b};
      for (int k = 0; k < 8; k++) begin
         r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'h00000000);
      end
      return r;
   endfunction

   // four bytes of a word, most significant byte first
   function automatic logic [31:0] crc_word(input logic [31:0] c, input logic [31:0] w);
      logic [31:0] r;
      r = c;
      for (int i = 3; i >= 0; i--) begin
         r = crc_byte(r, w[8*i +: 8]);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hdl/pcf_req_if.sv
// request channel: valid/ready handshake with the framer request payload
// depends on pcf_pkg
`default_nettype none

interface pcf_req_if;
   import pcf_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic [TYPE_BITS-1:0]      chunk_type;
   logic [LEN_FIELD_BITS-1:0] chunk_length;
   logic [BYTE_BITS-1:0]      data_byte;

   modport source (output valid, req_type, chunk_type, chunk_length, data_byte,
                   input ready);
   modport sink   (input valid, req_type, chunk_type, chunk_length, data_byte,
                   output ready);
endinterface

`default_nettype wire

### hdl/pcf_rsp_if.sv
// response channel: valid/ready handshake carrying one framed byte and its flags
// depends on pcf_pkg
`default_nettype none

interface pcf_rsp_if;
   import pcf_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] out_byte;
   logic                 last_of_run;
   logic                 chunk_done;
   logic [1:0]           status;

   modport source (output valid, out_byte, last_of_run, chunk_done, status,
                   input ready);
   modport sink   (input valid, out_byte, last_of_run, chunk_done, status,
                   output ready);
endinterface

`default_nettype wire

### hdl/png_chunk_framer_core.sv
// png chunk framer top level: input register, framer logic, result serializer
// one request per cycle when each causes one result and the result side takes it; an accepted
//   start causes 8 results (12 for an empty chunk), a closing data byte 5
// reset clears the input register, the result register and the chunk state (crc all ones)
// depends on pcf_pkg, pcf_req_if, pcf_rsp_if, pcf_in_stage, pcf_framer, pcf_serializer
`default_nettype none

module png_chunk_framer_core (
   input  wire logic   clock,
   input  wire logic   reset,
   pcf_req_if.sink     req_ch,
   pcf_rsp_if.source   rsp_ch
);
   import pcf_pkg::*;

   item_type item;
   logic     item_valid;
   logic     take;
   logic     run_free;
   run_type  run;

   pcf_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .take       (take),
      .item       (item),
      .item_valid (item_valid)
   );

   pcf_framer u_framer (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (item_valid),
      .run_free   (run_free),
      .take       (take),
      .run        (run)
   );

   pcf_serializer u_serializer (
      .clock    (clock),
      .reset    (reset),
      .run      (run),
      .load     (take),
      .run_free (run_free),
      .rsp_ch   (rsp_ch)
   );

endmodule

`default_nettype wire

### hdl/pcf_in_stage.sv
// input register: captures one request transaction and holds it for the framer
// depends on pcf_pkg and pcf_req_if
`default_nettype none

module pcf_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   pcf_req_if.sink                req_ch,
   input  wire logic              take,
   output pcf_pkg::item_type      item,
   output logic                   item_valid
);
   import pcf_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;

   // room when empty or when the held item moves on this cycle
   assign req_ch.ready = !valid_ff || take;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in             = 1'b1;
         item_in.req_type     = req_ch.req_type;
         item_in.chunk_type   = req_ch.chunk_type;
         item_in.chunk_length = req_ch.chunk_length;
         item_in.data_byte    = req_ch.data_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item       = item_ff;
   assign item_valid = valid_ff;

endmodule

`default_nettype wire

### hdl/pcf_framer.sv
// chunk state and crc: turns one request into a run of framed bytes
// depends on pcf_pkg
`default_nettype none

module pcf_framer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pcf_pkg::item_type item,
   input  wire logic              item_valid,
   input  wire logic              run_free,
   output logic                   take,
   output pcf_pkg::run_type       run
);
   import pcf_pkg::*;

   logic [31:0]            crc_ff, crc_in;
   logic [LENGTH_BITS-1:0] left_ff, left_in;
   logic                   open_ff, open_in;

   logic [LENGTH_BITS-1:0] len;
   logic [31:0]            len_word;
   logic [31:0]            crc_type;
   logic [31:0]            crc_data;
   logic [LENGTH_BITS-1:0] left_dec;

   assign take = item_valid && run_free;

   // excess length bits are ignored
   assign len      = item.chunk_length[LENGTH_BITS-1:0];
   assign len_word = {{(32-LENGTH_BITS){1'b0}}, len};
   assign crc_type = crc_word(CRC_INIT, item.chunk_type);
   assign crc_data = crc_byte(crc_ff, item.data_byte);
   assign left_dec = left_ff - {{(LENGTH_BITS-1){1'b0}}, 1'b1};

   // build the run and the next chunk state
   always_comb begin
      crc_in     = crc_ff;
      left_in    = left_ff;
      open_in    = open_ff;
      run.bytes  = '0;
      run.count  = RUN_CNT_BITS'(1);
      run.done   = 1'b0;
      run.status = STATUS_OK;
      if (item.req_type == REQ_START) begin
         if (open_ff) begin
            run.status = STATUS_CHUNK_OPEN;
         end else begin
            for (int i = 0; i < 4; i++) begin
               run.bytes[i]     = len_word[8*(3-i) +: 8];
               run.bytes[4 + i] = item.chunk_type[8*(3-i) +: 8];
            end
            if (len == '0) begin
               // empty chunk: crc follows the type at once
               for (int i = 0; i < 4; i++) begin
                  run.bytes[8 + i] = ~crc_type[8*(3-i) +: 8];
               end
               run.count = RUN_CNT_BITS'(12);
               run.done  = 1'b1;
               crc_in    = CRC_INIT;
            end else begin
               run.count = RUN_CNT_BITS'(8);
               crc_in    = crc_type;
               open_in   = 1'b1;
               left_in   = len;
            end
         end
      end else begin
         if (!open_ff) begin
            run.status = STATUS_NO_CHUNK;
         end else begin
            run.bytes[0] = item.data_byte;
            if (left_dec == '0) begin
               // last payload byte closes the chunk
               for (int i = 0; i < 4; i++) begin
                  run.bytes[1 + i] = ~crc_data[8*(3-i) +: 8];
               end
               run.count = RUN_CNT_BITS'(5);
               run.done  = 1'b1;
               crc_in    = CRC_INIT;
               open_in   = 1'b0;
               left_in   = '0;
            end else begin
               crc_in  = crc_data;
               left_in = left_dec;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= CRC_INIT;
         left_ff <= '0;
         open_ff <= 1'b0;
      end else if (take) begin
         crc_ff  <= crc_in;
         left_ff <= left_in;
         open_ff <= open_in;
      end
   end

endmodule

`default_nettype wire

### hdl/pcf_serializer.sv
// result register: holds one run and shifts it out one byte per transaction
// depends on pcf_pkg, pcf_rsp_if and the assertion macro header
`default_nettype none

`include "png_chunk_framer_core_assert.svh"

module pcf_serializer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pcf_pkg::run_type  run,
   input  wire logic              load,
   output logic                   run_free,
   pcf_rsp_if.source              rsp_ch
);
   import pcf_pkg::*;

   logic [RUN_MAX-1:0][BYTE_BITS-1:0] buf_ff, buf_in;
   logic [RUN_CNT_BITS-1:0]           cnt_ff, cnt_in;
   logic                              done_ff, done_in;
   status_type                        status_ff, status_in;
   logic                              busy;
   logic                              last;
   logic                              pop;

   assign busy     = (cnt_ff != '0);
   assign last     = (cnt_ff == RUN_CNT_BITS'(1));
   assign pop      = busy && rsp_ch.ready;
   assign run_free = !busy || (pop && last);

   // load a fresh run or shift the current one
   always_comb begin
      buf_in    = buf_ff;
      cnt_in    = cnt_ff;
      done_in   = done_ff;
      status_in = status_ff;
      if (load) begin
         buf_in    = run.bytes;
         cnt_in    = run.count;
         done_in   = run.done;
         status_in = run.status;
      end else if (pop) begin
         buf_in = {{BYTE_BITS{1'b0}}, buf_ff[RUN_MAX-1:1]};
         cnt_in = cnt_ff - RUN_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      buf_ff    <= buf_in;
      done_ff   <= done_in;
      status_ff <= status_in;
   end

   // response payload
   assign rsp_ch.valid       = busy;
   assign rsp_ch.out_byte    = buf_ff[0];
   assign rsp_ch.last_of_run = last;
   assign rsp_ch.chunk_done  = last && done_ff;
   assign rsp_ch.status      = status_ff;

   // checks
   `PCF_ASSERT_NOW(a_load_when_free, load, run_free, "run loaded over a pending run")
   `PCF_ASSERT_NEXT(a_run_continues, pop && !last, busy, "run ended before its last byte")
   `PCF_ASSERT_NOW(a_done_is_ok, busy && last && done_ff, status_ff == STATUS_OK,
                   "chunk end flagged on an error status")
   `PCF_ASSERT_NOW(a_error_single, busy && (status_ff != STATUS_OK), last,
                   "error status run longer than one transaction")

endmodule

`default_nettype wire

### tb/testbench.sv
// self-checking testbench for png_chunk_framer_core: directed and random chunk traffic
// depends on pcf_pkg, pcf_req_if, pcf_rsp_if and the framer rtl
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pcf_pkg::*;

   // one framed byte as it should leave the block
   typedef struct {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       chunk_done;
      logic [1:0] status;
   } framed_byte_type;

   // chunk framing predictor and byte stream checker
   class chunk_scoreboard_type;
      framed_byte_type expected_q[$];
      framed_byte_type run_q[$];
      logic [31:0]  crc_acc;
      logic [31:0]  bytes_left;
      bit           chunk_open;
      int           mismatches;
      int           received;

      function new();
         crc_acc    = CRC_INIT;
         bytes_left = 0;
         chunk_open = 0;
         mismatches = 0;
         received   = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // bit-serial reflected crc, data bits lsb first
      function logic [31:0] crc_update(logic [31:0] crc, logic [7:0] b);
         logic [31:0] c;
         c = crc;
         for (int k = 0; k < 8; k++) begin
            c = (c[0] ^ b[k]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
         end
         return c;
      endfunction

      function void add_byte(logic [7:0] b, logic done, status_type st);
         framed_byte_type r;
         r.out_byte    = b;
         r.last_of_run = 1'b0;
         r.chunk_done  = done;
         r.status      = st;
         run_q.push_back(r);
      endfunction

      // crc trailer, msb first, then back to no open chunk
      function void close_chunk();
         logic [31:0] v;
         v = ~crc_acc;
         add_byte(v[31:24], 1'b0, STATUS_OK);
         add_byte(v[23:16], 1'b0, STATUS_OK);
         add_byte(v[15:8],  1'b0, STATUS_OK);
         add_byte(v[7:0],   1'b1, STATUS_OK);
         chunk_open = 0;
         bytes_left = 0;
         crc_acc    = CRC_INIT;
      endfunction

      // work out every byte one accepted request causes
      function void note_request(logic rt, logic [31:0] ctype, logic [30:0] clen,
                                 logic [7:0] db);
         logic [31:0]     len_mask;
         logic [31:0]     len;
         framed_byte_type r;
         len_mask = (32'h1 << LENGTH_BITS) - 32'h1;
         len = {1'b0, clen} & len_mask;
         run_q.delete();
         if (rt == REQ_START) begin
            if (chunk_open) begin
               add_byte(8'h00, 1'b0, STATUS_CHUNK_OPEN);
            end else begin
               for (int i = 3; i >= 0; i--) add_byte(len[8*i +: 8], 1'b0, STATUS_OK);
               crc_acc = CRC_INIT;
               for (int i = 3; i >= 0; i--) begin
                  add_byte(ctype[8*i +: 8], 1'b0, STATUS_OK);
                  crc_acc = crc_update(crc_acc, ctype[8*i +: 8]);
               end
               if (len == 0) begin
                  close_chunk();
               end else begin
                  chunk_open = 1;
                  bytes_left = len;
               end
            end
         end else begin
            if (!chunk_open) begin
               add_byte(8'h00, 1'b0, STATUS_NO_CHUNK);
            end else begin
               add_byte(db, 1'b0, STATUS_OK);
               crc_acc = crc_update(crc_acc, db);
               bytes_left = bytes_left - 1;
               if (bytes_left == 0) close_chunk();
            end
         end
         foreach (run_q[k]) begin
            r = run_q[k];
            r.last_of_run = (k == run_q.size() - 1);
            expected_q.push_back(r);
         end
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= 40) $display("%0t mismatch: %s", $time, msg);
      endtask

      // compare one accepted result transaction with the oldest expected byte
      task check_response(logic [7:0] ob, logic last, logic done, logic [1:0] st);
         framed_byte_type want;
         received++;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result byte %02h status %0d", ob, st));
            return;
         end
         want = expected_q.pop_front();
         if (ob !== want.out_byte)
            report($sformatf("result %0d out_byte %02h, want %02h",
                             received, ob, want.out_byte));
         if (last !== want.last_of_run)
            report($sformatf("result %0d last_of_run %b, want %b",
                             received, last, want.last_of_run));
         if (done !== want.chunk_done)
            report($sformatf("result %0d chunk_done %b, want %b",
                             received, done, want.chunk_done));
         if (st !== want.status)
            report($sformatf("result %0d status %0d, want %0d",
                             received, st, want.status));
      endtask
   endclass

   logic clock;
   logic reset;

   pcf_req_if req_bus ();
   pcf_rsp_if rsp_bus ();

   chunk_scoreboard_type board = new();
   int items_sent;
   bit send_calm;
   bit drained;

   png_chunk_framer_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // timeout
   initial begin
      #8ms;
      $display("** png_chunk_framer_core: FAILED **");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_gap();
      if ($urandom_range(0, 9) < 7) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // monitor: check results first, then predict from the accepted request
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            board.check_response(rsp_bus.out_byte, rsp_bus.last_of_run,
                                 rsp_bus.chunk_done, rsp_bus.status);
         if (req_bus.valid && req_bus.ready)
            board.note_request(req_bus.req_type, req_bus.chunk_type,
                               req_bus.chunk_length, req_bus.data_byte);
      end
   end

   // result side back-pressure, with one long hold-off once traffic is flowing
   initial begin
      int  stall_left;
      int  hold_left;
      int  cycle;
      bit  hold_done;
      bit  calm;
      stall_left = 0;
      hold_left  = 0;
      cycle      = 0;
      hold_done  = 0;
      calm       = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         cycle++;
         if (cycle % 64 == 0) calm = ($urandom_range(0, 3) == 0);
         if (!hold_done && board.received >= 120) begin
            hold_done = 1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) stall_left = idle_gap();
         end
      end
   end

   // offer one request transaction, entered and left at a falling edge
   task automatic send_request(logic rt, logic [31:0] ctype, logic [30:0] clen,
                               logic [7:0] db);
      int gap;
      gap = (send_calm || $urandom_range(0, 1) == 0) ? 0 : idle_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.req_type     <= rt;
      req_bus.chunk_type   <= ctype;
      req_bus.chunk_length <= clen;
      req_bus.data_byte    <= db;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
      if (items_sent % 25 == 0) send_calm = ($urandom_range(0, 3) == 0);
   endtask

   task automatic send_start(logic [31:0] ctype, logic [30:0] clen);
      send_request(REQ_START, ctype, clen, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_data(logic [7:0] db);
      send_request(REQ_DATA, $urandom, 31'($urandom), db);
   endtask

   // stop offering until every predicted byte has come out
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (board.pending() != 0);
   endtask

   // well-formed chunk with random content, now and then a rejected start inside
   task automatic random_chunk();
      int len;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)      len = $urandom_range(0, 8);
      else if (pick < 95) len = $urandom_range(9, 40);
      else                len = $urandom_range(41, 100);
      send_start($urandom, 31'(len));
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 24) == 0) send_start($urandom, 31'($urandom_range(0, 50)));
         send_data(8'($urandom_range(0, 255)));
      end
   endtask

   // stimulus
   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.req_type     = REQ_START;
      req_bus.chunk_type   = '0;
      req_bus.chunk_length = '0;
      req_bus.data_byte    = '0;
      items_sent           = 0;
      send_calm            = 0;
      drained              = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // data with no open chunk, then empty chunks at the type extremes
      send_data(8'hFF);
      send_start(32'h00000000, 31'd0);
      send_start(32'hFFFFFFFF, 31'd0);
      // IHDR with payload extremes
      send_start(32'h49484452, 31'd3);
      send_data(8'h00);
      send_data(8'hFF);
      send_data(8'h5A);
      // IDAT with a start arriving while it is open
      send_start(32'h49444154, 31'd2);
      send_data(8'h12);
      send_start(32'hFFFFFFFF, 31'd5);
      send_data(8'h34);
      send_data(8'h00);
      // IEND, then a single byte chunk
      send_start(32'h49454E44, 31'd0);
      send_start(32'h74455874, 31'd1);
      send_data(8'hA5);

      // random traffic, one full drain part way through
      while (items_sent < 300) begin
         if (!drained && items_sent >= 160) begin
            drained = 1;
            drain_results();
         end
         if ($urandom_range(0, 19) == 0) send_data(8'($urandom_range(0, 255)));
         else random_chunk();
      end

      // widest length field: chunk stays open to the end
      send_start($urandom, 31'h7FFFFFFF);
      repeat (6) send_data(8'($urandom_range(0, 255)));
      send_start(32'hFFFFFFFF, 31'd0);
      send_data(8'($urandom_range(0, 255)));

      drain_results();
      repeat (30) @(negedge clock);
      if (board.mismatches == 0)
         $display("** png_chunk_framer_core: PASSED **");
      else
         $display("** png_chunk_framer_core: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
